// File: src/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants for the FIFO page replacement block.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;

  localparam int PAGE_NUM_W = 16;
  localparam int FIU_W      = 4;
  localparam int SLOT_W     = 3;
  localparam int COUNT_W    = 16;

  localparam logic [FIU_W-1:0]   FIU_RESET = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_COMMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_page;
    logic capture_match;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

// File: src/fpr_ctrl.sv
// ----------------------------------------------------------------------------
// fpr_ctrl
// Sequencer for one page request: latch, compare, commit.
// ----------------------------------------------------------------------------
module fpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fpr_pkg::dp_status_t status_i,
  output fpr_pkg::dp_cmd_t    cmd_o
);
  import fpr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MATCH;
      end
      ST_MATCH: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o          = 1'b1;
    cmd_o.load_page     = 1'b0;
    cmd_o.capture_match = 1'b0;
    cmd_o.commit        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_page = in_valid_i;
      end
      ST_MATCH: begin
        cmd_o.capture_match = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = !status_i.out_busy;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_to_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_MATCH))
    else $error("accepted request did not move to compare");
`endif

endmodule

// File: src/fpr_datapath.sv
// ----------------------------------------------------------------------------
// fpr_datapath
// Frame store, parallel compare, FIFO pointer, counters and result register.
// ----------------------------------------------------------------------------
module fpr_datapath #(
  parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fpr_pkg::dp_cmd_t                cmd_i,
  output fpr_pkg::dp_status_t             status_o,
  input  logic                            cfg_we_i,
  input  logic [fpr_pkg::FIU_W-1:0]       cfg_data_i,
  input  logic [fpr_pkg::PAGE_NUM_W-1:0]  page_number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic [fpr_pkg::SLOT_W-1:0]      frame_slot_o,
  output logic [fpr_pkg::COUNT_W-1:0]     hit_total_o,
  output logic [fpr_pkg::COUNT_W-1:0]     fault_total_o
);
  import fpr_pkg::*;

  localparam int PTR_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  logic [FIU_W-1:0]      fiu_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [PAGE_BITS-1:0]  frame_page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid_q;
  logic [MAX_FRAMES-1:0] match_q;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [COUNT_W-1:0]    hit_cnt_q, hit_cnt_d;
  logic [COUNT_W-1:0]    fault_cnt_q, fault_cnt_d;
  logic                  out_valid_q;
  logic                  hit_q;
  logic [SLOT_W-1:0]     slot_q;

  logic [PAGE_BITS+PAGE_NUM_W-1:0] page_wide;
  logic [CNT_W-1:0]      act_n;
  logic [PTR_W-1:0]      ptr_eff;
  logic [CNT_W-1:0]      ptr_inc;
  logic [PTR_W-1:0]      hit_idx;
  logic                  found;
  logic [PTR_W-1:0]      slot_sel;
  logic [PTR_W+SLOT_W-1:0] slot_wide;

  // low PAGE_BITS of the request, zero-extended where PAGE_BITS is wider
  assign page_wide = {{PAGE_BITS{1'b0}}, page_number_i};

  // clamp the frame count to 1..MAX_FRAMES
  always_comb begin
    priority if (fiu_q == '0) begin
      act_n = CNT_W'(1);
    end else if (int'(fiu_q) > MAX_FRAMES) begin
      act_n = CNT_W'(MAX_FRAMES);
    end else begin
      act_n = CNT_W'(fiu_q);
    end
  end

  // lowest matching frame
  always_comb begin
    hit_idx = '0;
    for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
      if (match_q[k]) hit_idx = PTR_W'(k);
    end
  end

  assign found = |match_q;

  // wrap the pointer first if the frame count shrank under it
  assign ptr_eff = (CNT_W'(ptr_q) >= act_n) ? '0 : ptr_q;
  assign ptr_inc = CNT_W'(ptr_eff) + CNT_W'(1);
  assign ptr_d   = (ptr_inc == act_n) ? '0 : PTR_W'(ptr_inc);

  assign slot_sel  = found ? hit_idx : ptr_eff;
  assign slot_wide = {{SLOT_W{1'b0}}, slot_sel};

  assign hit_cnt_d   = (found && hit_cnt_q != COUNT_MAX) ? hit_cnt_q + 1'b1 : hit_cnt_q;
  assign fault_cnt_d = (!found && fault_cnt_q != COUNT_MAX) ? fault_cnt_q + 1'b1
                                                            : fault_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q         <= FIU_RESET;
      frame_valid_q <= '0;
      match_q       <= '0;
      ptr_q         <= '0;
      hit_cnt_q     <= '0;
      fault_cnt_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) fiu_q <= cfg_data_i;
      if (cmd_i.capture_match) begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
          match_q[k] <= frame_valid_q[k] && (frame_page_q[k] == page_q) &&
                        (k < int'(act_n));
        end
      end
      if (cmd_i.commit) begin
        hit_cnt_q   <= hit_cnt_d;
        fault_cnt_q <= fault_cnt_d;
        if (!found) begin
          frame_valid_q[ptr_eff] <= 1'b1;
          ptr_q                  <= ptr_d;
        end
      end
      // drop the result once taken, raise on a fresh commit
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_page) page_q <= page_wide[PAGE_BITS-1:0];
    if (cmd_i.commit) begin
      hit_q  <= found;
      slot_q <= slot_wide[SLOT_W-1:0];
      if (!found) frame_page_q[ptr_eff] <= page_q;
    end
  end

  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign frame_slot_o  = slot_q;
  assign hit_total_o   = hit_cnt_q;
  assign fault_total_o = fault_cnt_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && out_stall_i))
    else $error("result committed over a stalled result");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(ptr_q) < MAX_FRAMES)
    else $error("FIFO pointer outside the frame store");

  a_fault_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && !found) |=> frame_valid_q[$past(ptr_eff)])
    else $error("faulted frame not marked valid");
`endif

endmodule

// File: src/fifo_page_replacement.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement
// FIFO page replacement over up to MAX_FRAMES frames. Each page request is
// compared against every valid frame below the programmed frame count
// (0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES); a match returns
// a hit with the lowest matching frame, otherwise the page is written into
// the frame under the FIFO pointer and a fault is returned. Hit and fault
// totals saturate at 65535. A request is latched at acceptance and its result
// is written to the output register at commit, after a registered parallel
// compare; pointer, frame and counters commit in the controller's sequence.
// The input is stalled through compare and commit, so no new request is taken
// before the last has committed; the commit waits while the previous result is
// still stalled, and the next request may be accepted as soon as the commit
// is done. Write frames_in_use only while no request is in flight.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
  parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fpr_pkg::FIU_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fpr_pkg::PAGE_NUM_W-1:0]  page_number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            hit_o,
  output logic [fpr_pkg::SLOT_W-1:0]      frame_slot_o,
  output logic [fpr_pkg::COUNT_W-1:0]     hit_total_o,
  output logic [fpr_pkg::COUNT_W-1:0]     fault_total_o
);
  import fpr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  fpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpr_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .page_number_i (page_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .frame_slot_o  (frame_slot_o),
    .hit_total_o   (hit_total_o),
    .fault_total_o (fault_total_o)
  );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for fifo_page_replacement. Page requests are driven
// through the valid/stall input and every result is compared field by field
// against an in-bench FIFO replacement predictor. Coverage comes from
// directed frame-count corner cases, random working-set traffic under varied
// idling and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import fpr_pkg::*;

  localparam int NFRAMES       = MAX_FRAMES_DEF;
  localparam int STUCK_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
  } page_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [FIU_W-1:0]      cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [PAGE_NUM_W-1:0] page_number_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic                  hit_o;
  logic [SLOT_W-1:0]     frame_slot_o;
  logic [COUNT_W-1:0]    hit_total_o;
  logic [COUNT_W-1:0]    fault_total_o;

  // predictor state
  logic [PAGE_NUM_W-1:0] frame_pages [NFRAMES];
  logic                  frame_used  [NFRAMES];
  int unsigned           next_victim;
  logic [COUNT_W-1:0]    hit_tally;
  logic [COUNT_W-1:0]    fault_tally;
  logic [FIU_W-1:0]      frames_cfg;
  page_result_t          results_due [$];

  int mismatches       = 0;
  int src_idle_pct     = 0;
  int sink_idle_pct    = 0;
  int sink_hold_cycles = 0;
  int stuck_cycles     = 0;

  fifo_page_replacement dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .page_number_i (page_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hit_o         (hit_o),
    .frame_slot_o  (frame_slot_o),
    .hit_total_o   (hit_total_o),
    .fault_total_o (fault_total_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic page_result_t resolve_page(logic [PAGE_NUM_W-1:0] pg);
    page_result_t r;
    int unsigned  n;
    logic         found;
    n     = (frames_cfg == 0) ? 1 : (frames_cfg > NFRAMES) ? NFRAMES : frames_cfg;
    found = 1'b0;
    r     = '0;
    // lowest matching frame wins; empty frames never match
    for (int k = 0; k < n; k++) begin
      if (!found && frame_used[k] && frame_pages[k] == pg) begin
        found  = 1'b1;
        r.slot = SLOT_W'(k);
      end
    end
    if (found) begin
      if (hit_tally != COUNT_MAX) hit_tally++;
    end else begin
      if (next_victim >= n) next_victim = 0;
      r.slot                   = SLOT_W'(next_victim);
      frame_pages[next_victim] = pg;
      frame_used[next_victim]  = 1'b1;
      next_victim              = (next_victim + 1) % n;
      if (fault_tally != COUNT_MAX) fault_tally++;
    end
    r.hit    = found;
    r.hits   = hit_tally;
    r.faults = fault_tally;
    return r;
  endfunction

  task automatic set_idling(input int src_pct, input int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Enter and leave at a falling edge; valid stays high for a following request.
  task automatic send_page(input logic [PAGE_NUM_W-1:0] pg);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= pg;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    results_due.push_back(resolve_page(pg));
    @(negedge clk_i);
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_frame_count(input logic [FIU_W-1:0] count);
    drain_requests();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    frames_cfg = count;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    // fill all eight frames; page zero must fault against the empty frames
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h8000);
    send_page(16'h0001);
    send_page(16'h5555);
    send_page(16'hAAAA);
    send_page(16'h1234);
    send_page(16'h00F0);
    send_page(16'h00F0);
    send_page(16'h0000);
    send_page(16'h4321);
    send_page(16'h0F0F);
    // count of zero acts as one; pointer beyond the count wraps to frame 0
    write_frame_count(4'd0);
    send_page(16'h1234);
    send_page(16'h1234);
    // oversized count acts as eight; frames 0 and 6 both match
    write_frame_count(4'd15);
    send_page(16'h1234);
    send_page(16'hAAAA);
    write_frame_count(4'd2);
    send_page(16'hAAAA);
    send_page(16'h0F0F);
    write_frame_count(FIU_RESET);
  endtask

  task automatic test_random_traffic();
    logic [PAGE_NUM_W-1:0] pool [16];
    logic [FIU_W-1:0]      edge_counts [4] = '{4'd1, 4'd8, 4'd0, 4'd15};
    int                    pool_len;
    for (int chunk = 0; chunk < 14; chunk++) begin
      if (chunk == 5) set_idling(76, 37);
      if (chunk == 10) set_idling(0, 0);
      write_frame_count(chunk < 4 ? edge_counts[chunk] : FIU_W'($urandom_range(0, 15)));
      pool_len = $urandom_range(1, 12);
      for (int k = 0; k < 16; k++) pool[k] = PAGE_NUM_W'($urandom);
      // mostly a small working set so hits are frequent, the rest stray pages
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 99) < 80) send_page(pool[$urandom_range(0, pool_len - 1)]);
        else send_page(PAGE_NUM_W'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    sink_hold_cycles = 300;
    for (int i = 0; i < 24; i++) send_page(PAGE_NUM_W'($urandom_range(0, 15)));
    drain_requests();
    for (int i = 0; i < 24; i++) send_page(PAGE_NUM_W'($urandom_range(0, 15)));
    drain_requests();
  endtask

  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    page_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $error("result with no page request outstanding");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit_o);
          mismatches++;
        end
        if (frame_slot_o !== want.slot) begin
          $error("frame_slot: expected %0d, actual %0d", want.slot, frame_slot_o);
          mismatches++;
        end
        if (hit_total_o !== want.hits) begin
          $error("hit_total: expected %0d, actual %0d", want.hits, hit_total_o);
          mismatches++;
        end
        if (fault_total_o !== want.faults) begin
          $error("fault_total: expected %0d, actual %0d", want.faults, fault_total_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int k = 0; k < NFRAMES; k++) begin
      frame_pages[k] = '0;
      frame_used[k]  = 1'b0;
    end
    next_victim = 0;
    hit_tally   = '0;
    fault_tally = '0;
    frames_cfg  = FIU_RESET;
    set_idling(37, 76);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic();
    test_backpressure();
    drain_requests();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
